/* hdl/prc_pkg.sv */
package prc_pkg;

  // Coordinate format: signed Q16.8
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CNT_OUT_W = 7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       start_new;
    coord_t     point_a_x;
    coord_t     point_a_z;
    coord_t     point_b_x;
    coord_t     point_b_z;
  } prc_in_t;

  typedef struct packed {
    logic                 inside_res;
    logic                 rect_ok;
    logic [CNT_OUT_W-1:0] crossings;
    logic [CNT_OUT_W-1:0] vertex_count;
    logic                 overflow;
  } prc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } prc_state_t;

endpackage

/* hdl/prc_ram.sv */
module prc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/polygon_region_containment_top.sv */
// Point-in-polygon and segment-vs-polygon tests in the XZ plane.
// Input channel (in_valid/in_stall/in_data) carries one item per transfer:
// a vertex load, a point query or a pair query. Every item produces exactly
// one result transfer on out_valid/out_stall/out_data.
// Loads write the vertex memory and update the bounding box, then move
// to ST_FIN, which registers the result once the output slot is free.
// A query walks the vertex memory one vertex per cycle (n + 1 reads for n
// stored vertices, the first vertex read again for the closing edge); the
// products of each edge are registered and then added to the crossing
// count, and ST_DRAIN waits for this to finish before ST_FIN registers the
// result. With no stored vertex a query goes straight to ST_FIN.
// The single read port of the vertex memory sets that rate: one edge tested
// per cycle.
// One item is in flight at a time; a new item is taken once the previous
// result has moved into the output register, even if that result is still
// waiting for the receiver. While out_stall holds, the output register keeps
// its data and a finished item waits in place, which backs up in_stall.
// Reset empties the polygon and clears the box; the vertex memory itself is
// not cleared, only entries below the vertex count are ever read.
module polygon_region_containment_top
  import prc_pkg::*;
#(
  parameter int MAX_VERTS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  prc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output prc_out_t out_data
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int TW = $clog2(MAX_VERTS + 1);
  localparam int VW = 2 * COORD_W;

  prc_state_t state_r, state_nxt;

  logic [TW-1:0] total_r;
  logic [TW-1:0] cnt_r;
  logic [TW-1:0] count_r;
  coord_t        box_min_x_r, box_min_z_r, box_max_x_r, box_max_z_r;
  logic [1:0]    op_r;
  logic          ovf_r;
  coord_t        qa_x_r, qa_z_r, qb_x_r, qb_z_r;

  logic          rd_v_r, rd_first_r;
  coord_t        prev_x_r, prev_z_r;
  logic          p_v_r;
  prod_t         prod_r [8];

  logic          out_valid_r;
  prc_out_t      out_data_r;

  logic          accept;
  logic          slot_free;
  logic          scan_last;

  // Memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  // Load path
  logic [TW-1:0] base_total;
  coord_t        base_min_x, base_min_z, base_max_x, base_max_z;
  logic          load_ok;

  // Edge test path
  coord_t        cur_x, cur_z;
  diff_t         d_abx, d_abz, d_acx, d_acz, d_adx, d_adz;
  diff_t         d_cdx, d_cdz, d_cax, d_caz, d_cbx, d_cbz;
  prod_t         prod_nxt [8];
  logic          t1, t2, t3, t4, edge_cross;

  // Result path
  logic          in_a, in_b;
  prc_out_t      res;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign scan_last = (cnt_r == total_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  prc_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTS)
  ) u_vert_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load: optional restart, then append if there is room
  always_comb begin
    base_total = in_data.start_new ? '0 : total_r;
    base_min_x = in_data.start_new ? COORD_MAX : box_min_x_r;
    base_min_z = in_data.start_new ? COORD_MAX : box_min_z_r;
    base_max_x = in_data.start_new ? COORD_MIN : box_max_x_r;
    base_max_z = in_data.start_new ? COORD_MIN : box_max_z_r;
    load_ok    = (base_total < TW'(MAX_VERTS));
  end

  assign ram_we    = accept && (in_data.op == OP_LOAD) && load_ok;
  assign ram_waddr = base_total[AW-1:0];
  assign ram_wdata = {in_data.point_a_x, in_data.point_a_z};

  // Vertex walk: 0 .. n-1, then vertex 0 again for the closing edge
  assign ram_re    = (state_r == ST_SCAN);
  assign ram_raddr = scan_last ? '0 : cnt_r[AW-1:0];

  // State machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_POINT, OP_PAIR: state_nxt = (total_r == '0) ? ST_FIN : ST_SCAN;
            default:           state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !p_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Item capture and polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      box_min_x_r <= COORD_MAX;
      box_min_z_r <= COORD_MAX;
      box_max_x_r <= COORD_MIN;
      box_max_z_r <= COORD_MIN;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_data.op == OP_LOAD)) begin
        if (load_ok) begin
          total_r     <= base_total + TW'(1);
          box_min_x_r <= (in_data.point_a_x < base_min_x) ? in_data.point_a_x : base_min_x;
          box_min_z_r <= (in_data.point_a_z < base_min_z) ? in_data.point_a_z : base_min_z;
          box_max_x_r <= (in_data.point_a_x > base_max_x) ? in_data.point_a_x : base_max_x;
          box_max_z_r <= (in_data.point_a_z > base_max_z) ? in_data.point_a_z : base_max_z;
        end
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + TW'(1);
      end
    end
  end

  // Query operands; a point query casts its ray to the far right
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.op;
      ovf_r  <= (in_data.op == OP_LOAD) && !load_ok;
      qa_x_r <= in_data.point_a_x;
      qa_z_r <= in_data.point_a_z;
      if (in_data.op == OP_POINT) begin
        qb_x_r <= COORD_MAX;
        qb_z_r <= in_data.point_a_z;
      end else begin
        qb_x_r <= in_data.point_b_x;
        qb_z_r <= in_data.point_b_z;
      end
    end
  end

  // Read tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      p_v_r  <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_SCAN);
      p_v_r  <= rd_v_r && !rd_first_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (cnt_r == '0);
    if (rd_v_r) begin
      prev_x_r <= cur_x;
      prev_z_r <= cur_z;
    end
  end

  // Edge c->d is (previous vertex, vertex just read); segment is a->b
  always_comb begin
    cur_x = coord_t'(ram_rdata[VW-1:COORD_W]);
    cur_z = coord_t'(ram_rdata[COORD_W-1:0]);

    d_abx = diff_t'(qb_x_r) - diff_t'(qa_x_r);
    d_abz = diff_t'(qb_z_r) - diff_t'(qa_z_r);
    d_acx = diff_t'(prev_x_r) - diff_t'(qa_x_r);
    d_acz = diff_t'(prev_z_r) - diff_t'(qa_z_r);
    d_adx = diff_t'(cur_x) - diff_t'(qa_x_r);
    d_adz = diff_t'(cur_z) - diff_t'(qa_z_r);

    d_cdx = diff_t'(cur_x) - diff_t'(prev_x_r);
    d_cdz = diff_t'(cur_z) - diff_t'(prev_z_r);
    d_cax = diff_t'(qa_x_r) - diff_t'(prev_x_r);
    d_caz = diff_t'(qa_z_r) - diff_t'(prev_z_r);
    d_cbx = diff_t'(qb_x_r) - diff_t'(prev_x_r);
    d_cbz = diff_t'(qb_z_r) - diff_t'(prev_z_r);

    prod_nxt[0] = d_abx * d_acz;
    prod_nxt[1] = d_abz * d_acx;
    prod_nxt[2] = d_abx * d_adz;
    prod_nxt[3] = d_abz * d_adx;
    prod_nxt[4] = d_cdx * d_caz;
    prod_nxt[5] = d_cdz * d_cax;
    prod_nxt[6] = d_cdx * d_cbz;
    prod_nxt[7] = d_cdz * d_cbx;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

  // Strict orientation compares and crossing count
  always_comb begin
    t1 = prod_r[0] > prod_r[1];
    t2 = prod_r[2] > prod_r[3];
    t3 = prod_r[4] > prod_r[5];
    t4 = prod_r[6] > prod_r[7];
    edge_cross = (t1 != t2) && (t3 != t4);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= '0;
    end else if (p_v_r && edge_cross) begin
      count_r <= count_r + TW'(1);
    end
  end

  // Result assembly
  always_comb begin
    in_a = (qa_x_r >= box_min_x_r) && (qa_x_r < box_max_x_r) &&
           (qa_z_r >= box_min_z_r) && (qa_z_r < box_max_z_r);
    in_b = (qb_x_r >= box_min_x_r) && (qb_x_r < box_max_x_r) &&
           (qb_z_r >= box_min_z_r) && (qb_z_r < box_max_z_r);

    res.rect_ok      = (box_min_x_r < box_max_x_r) && (box_min_z_r < box_max_z_r);
    res.vertex_count = CNT_OUT_W'(total_r);
    res.overflow     = ovf_r;
    case (op_r)
      OP_POINT: begin
        res.inside_res = in_a && count_r[0];
        res.crossings  = CNT_OUT_W'(count_r);
      end
      OP_PAIR: begin
        res.inside_res = in_a && in_b && (count_r == '0);
        res.crossings  = CNT_OUT_W'(count_r);
      end
      default: begin
        res.inside_res = 1'b0;
        res.crossings  = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && slot_free) begin
      out_data_r <= res;
    end
  end

endmodule

/* tb/sv/polygon_region_containment_top_tb.sv */
module polygon_region_containment_top_tb
  import prc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTS = 64;
  localparam int ITEMS = 400;
  localparam int PHASE1_AT = 140;
  localparam int PHASE2_AT = 280;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  prc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  prc_out_t out_data;

  polygon_region_containment_top #(.MAX_VERTS(MAX_VERTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Polygon state as seen by the checker
  coord_t      vert_x [MAX_VERTS];
  coord_t      vert_z [MAX_VERTS];
  int unsigned vert_cnt;
  coord_t      box_lo_x, box_lo_z, box_hi_x, box_hi_z;

  prc_out_t    pending_results [$];
  int unsigned items_sent = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned fail_cnt = 0;
  longint      cycle_cnt = 0;

  typedef struct packed {
    prc_in_t  item;
    logic     typed;
    prc_out_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void clear_polygon();
    vert_cnt = 0;
    box_lo_x = COORD_MAX;
    box_lo_z = COORD_MAX;
    box_hi_x = COORD_MIN;
    box_hi_z = COORD_MIN;
  endfunction

  // Strict left turn of p -> q -> r, exact in 64 bits
  function automatic bit left_turn(coord_t px, coord_t pz, coord_t qx, coord_t qz,
                                   coord_t rx, coord_t rz);
    longint lhs, rhs;
    lhs = (longint'(qx) - longint'(px)) * (longint'(rz) - longint'(pz));
    rhs = (longint'(qz) - longint'(pz)) * (longint'(rx) - longint'(px));
    return lhs > rhs;
  endfunction

  function automatic bit segs_intersect(coord_t ax, coord_t az, coord_t bx, coord_t bz,
                                        coord_t cx, coord_t cz, coord_t dx, coord_t dz);
    if (left_turn(ax, az, bx, bz, cx, cz) == left_turn(ax, az, bx, bz, dx, dz))
      return 1'b0;
    return left_turn(cx, cz, dx, dz, ax, az) != left_turn(cx, cz, dx, dz, bx, bz);
  endfunction

  // Edges hit by segment a-b, closing edge included
  function automatic int unsigned edges_hit(coord_t ax, coord_t az, coord_t bx, coord_t bz);
    int unsigned hits, nxt;
    hits = 0;
    for (int unsigned i = 0; i < vert_cnt; i++) begin
      nxt = (i + 1 < vert_cnt) ? i + 1 : 0;
      if (segs_intersect(ax, az, bx, bz, vert_x[i], vert_z[i], vert_x[nxt], vert_z[nxt]))
        hits++;
    end
    return hits;
  endfunction

  function automatic bit in_bbox(coord_t x, coord_t z);
    return x >= box_lo_x && x < box_hi_x && z >= box_lo_z && z < box_hi_z;
  endfunction

  // Apply one item to the polygon state and return its result
  function automatic prc_out_t region_result(prc_in_t it);
    prc_out_t    res;
    int unsigned hits;
    res = '0;
    hits = 0;
    case (it.op)
      OP_LOAD: begin
        if (it.start_new) clear_polygon();
        if (vert_cnt < MAX_VERTS) begin
          vert_x[vert_cnt] = it.point_a_x;
          vert_z[vert_cnt] = it.point_a_z;
          vert_cnt++;
          if (it.point_a_x < box_lo_x) box_lo_x = it.point_a_x;
          if (it.point_a_x > box_hi_x) box_hi_x = it.point_a_x;
          if (it.point_a_z < box_lo_z) box_lo_z = it.point_a_z;
          if (it.point_a_z > box_hi_z) box_hi_z = it.point_a_z;
        end else begin
          res.overflow = 1'b1;
        end
      end
      OP_POINT: begin
        hits = edges_hit(it.point_a_x, it.point_a_z, COORD_MAX, it.point_a_z);
        res.inside_res = in_bbox(it.point_a_x, it.point_a_z) && hits[0];
      end
      OP_PAIR: begin
        hits = edges_hit(it.point_a_x, it.point_a_z, it.point_b_x, it.point_b_z);
        res.inside_res = in_bbox(it.point_a_x, it.point_a_z) &&
                         in_bbox(it.point_b_x, it.point_b_z) && hits == 0;
      end
      default: ;
    endcase
    res.rect_ok      = box_lo_x < box_hi_x && box_lo_z < box_hi_z;
    res.crossings    = hits[CNT_OUT_W-1:0];
    res.vertex_count = vert_cnt[CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic prc_in_t mk_item(logic [1:0] op, logic sn, coord_t ax, coord_t az,
                                      coord_t bx, coord_t bz);
    prc_in_t it;
    it.op        = op;
    it.start_new = sn;
    it.point_a_x = ax;
    it.point_a_z = az;
    it.point_b_x = bx;
    it.point_b_z = bz;
    return it;
  endfunction

  function automatic dir_row_t mk_row(prc_in_t it, logic typed, logic ins, logic rect,
                                      int hits, int vc);
    dir_row_t r;
    r.item               = it;
    r.typed              = typed;
    r.want.inside_res    = ins;
    r.want.rect_ok       = rect;
    r.want.crossings     = hits[CNT_OUT_W-1:0];
    r.want.vertex_count  = vc[CNT_OUT_W-1:0];
    r.want.overflow      = 1'b0;
    return r;
  endfunction

  function automatic coord_t pick_coord(longint lo, longint hi);
    if (lo < COORD_MIN) lo = COORD_MIN;
    if (hi > COORD_MAX) hi = COORD_MAX;
    return coord_t'(lo + longint'($urandom_range(int'(hi - lo), 0)));
  endfunction

  // Coordinate in or just around [lo, hi]
  function automatic coord_t near_range(coord_t lo, coord_t hi);
    longint a, b, m;
    a = lo;
    b = hi;
    if (a > b) begin
      a = hi;
      b = lo;
    end
    m = (b - a) / 4 + 2;
    return pick_coord(a - m, b + m);
  endfunction

  // Offer one item, wait for its transfer, queue what it should produce
  task automatic send_item(input prc_in_t it, input logic typed, input prc_out_t typed_res);
    prc_out_t res;
    if (items_sent < PHASE1_AT) begin
      src_idle_pct = 26;
      snk_stall_pct = 76;
    end else if (items_sent < PHASE2_AT) begin
      src_idle_pct = 76;
      snk_stall_pct = 26;
    end else begin
      src_idle_pct = 0;
      snk_stall_pct = 0;
    end
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    res = region_result(it);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_checked(input prc_in_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < snk_stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin : result_mon
    prc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("inside_res", want.inside_res, out_data.inside_res);
        check_field("rect_ok", want.rect_ok, out_data.rect_ok);
        check_field("crossings", want.crossings, out_data.crossings);
        check_field("vertex_count", want.vertex_count, out_data.vertex_count);
        check_field("overflow", want.overflow, out_data.overflow);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned sel, nv, nq, radius, idx;
    int          round;
    coord_t      cx, cz, ax, az, bx, bz;
    logic [1:0]  op;
    prc_in_t     it;

    clear_polygon();

    // Directed rows: typed expectations where the answer is obvious, the checker's own result elsewhere
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_PAIR, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN),
                              1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_UNUSED, 1, COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MAX), 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 1, COORD_MIN, COORD_MIN, 0, 0), 1, 0, 0, 0, 1));
    // single vertex: the closing edge is a point
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, COORD_MIN, COORD_MIN, 0, 0),
                              1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN),
                              1, 0, 1, 0, 2));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 0, COORD_MAX, COORD_MIN, 0, 0), 1, 0, 1, 0, 3));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 1, COORD_MIN, COORD_MIN, 0, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, coord_t'(COORD_MAX - 1),
                                      coord_t'(COORD_MIN + 1), 0, 0),
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_PAIR, 0, COORD_MIN, 0, COORD_MAX, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_UNUSED, 0, 0, 0, 0, 0), 1, 0, 1, 0, 3));
    // unit square of 1.0 on each side
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 1, 0, 0, 0, 0), 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 0, 256, 0, 0, 0), 1, 0, 0, 0, 2));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 0, 256, 256, 0, 0), 1, 0, 1, 0, 3));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 0, 0, 256, 0, 0), 1, 0, 1, 0, 4));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, 128, 128, 0, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, -1, 128, 0, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_POINT, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_PAIR, 0, 64, 64, 192, 192), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_PAIR, 0, 64, 64, 512, 64), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_PAIR, 1, 128, -128, 128, 384), 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(mk_item(OP_LOAD, 1, -256, -256, COORD_MIN, COORD_MAX),
                              1, 0, 0, 0, 1));

    // Hold synchronous reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random rounds: mostly a polygon followed by queries, some noise
    round = 0;
    while (items_sent < ITEMS) begin
      sel = $urandom_range(99, 0);
      if (round == 0 || sel < 10) nv = $urandom_range(MAX_VERTS + 6, MAX_VERTS);
      else if (sel < 18) nv = $urandom_range(2, 1);
      else if (sel < 75) nv = $urandom_range(10, 3);
      else nv = 0;

      if (nv == 0) begin
        // full-range items of any op
        repeat ($urandom_range(4, 1)) begin
          it = mk_item(2'($urandom_range(3, 0)), 1'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
          send_checked(it);
        end
      end else begin
        case ($urandom_range(3, 0))
          0: radius = 4;
          1: radius = 256;
          2: radius = 65536;
          default: radius = 1 << 23;
        endcase
        cx = coord_t'($urandom);
        cz = coord_t'($urandom);
        for (int unsigned i = 0; i < nv; i++) begin
          ax = pick_coord(longint'(cx) - radius, longint'(cx) + radius);
          az = pick_coord(longint'(cz) - radius, longint'(cz) + radius);
          send_checked(mk_item(OP_LOAD, i == 0, ax, az, coord_t'($urandom),
                               coord_t'($urandom)));
        end
        nq = $urandom_range(8, 3);
        repeat (nq) begin
          sel = $urandom_range(99, 0);
          op = (sel < 45) ? OP_POINT : (sel < 93) ? OP_PAIR : OP_UNUSED;
          if (vert_cnt != 0 && $urandom_range(4, 0) == 0) begin
            idx = $urandom_range(vert_cnt - 1, 0);
            ax = vert_x[idx];
            az = vert_z[idx];
          end else begin
            ax = near_range(box_lo_x, box_hi_x);
            az = near_range(box_lo_z, box_hi_z);
          end
          if (vert_cnt != 0 && $urandom_range(4, 0) == 0) begin
            idx = $urandom_range(vert_cnt - 1, 0);
            bx = vert_x[idx];
            bz = vert_z[idx];
          end else begin
            bx = near_range(box_lo_x, box_hi_x);
            bz = near_range(box_lo_z, box_hi_z);
          end
          send_checked(mk_item(op, 1'($urandom), ax, az, bx, bz));
        end
      end
      round++;
    end

    // Drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
